// ----- hdl/slrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slrg_pkg;

  localparam int unsigned DIVN_W = 48;
  localparam int unsigned DIVD_W = 34;
  localparam int unsigned DCNT_W = $clog2(DIVN_W);

  localparam logic [1:0] CFG_ALPHA_FREQ = 2'd0;
  localparam logic [1:0] CFG_FIRST_SCALE = 2'd1;
  localparam logic [1:0] CFG_ALPHA_SQ = 2'd2;
  localparam logic [1:0] CFG_ALPHA_X20K = 2'd3;

  localparam logic [31:0] RST_ALPHA_FREQ = 32'd3141592;
  localparam logic [15:0] RST_FIRST_SCALE = 16'd6760;
  localparam logic [31:0] RST_ALPHA_SQ = 32'd628318530;
  localparam logic [15:0] RST_ALPHA_X20K = 16'd628;

  localparam logic ACT_MOVE = 1'b0;
  localparam logic ACT_EVENT = 1'b1;

  localparam logic [15:0] MOVE_DELAY = 16'd100;
  localparam logic [15:0] SINGLE_DELAY = 16'd1000;
  localparam logic [33:0] SCALE_DIV = 34'd100;
  localparam logic [31:0] SQ_TOP_BIT = 32'h4000_0000;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_DEN_MUL,
    S_DEN_DIV,
    S_MIN_DIV,
    S_T_DIV,
    S_ROOT,
    S_FIRST_MUL,
    S_FIRST_DIV,
    S_MAXS_MUL,
    S_MAXS_DIV,
    S_AL_MUL,
    S_AL_DIV,
    S_DV_CHK,
    S_DV_MUL,
    S_DV_DIV,
    S_MV_FIN,
    S_MV_TAIL,
    S_EV_DIV,
    S_OUT
  } seq_e;

  typedef struct packed {
    logic               action;
    logic signed [31:0] move_steps;
    logic [15:0]        accel_rate;
    logic [15:0]        decel_rate;
    logic [15:0]        top_speed;
  } in_word_t;

  typedef struct packed {
    logic [15:0] compare_delay;
    logic        running;
    logic        direction;
    logic [1:0]  ramp_state;
  } out_word_t;

  function automatic logic [15:0] sat16(input logic signed [49:0] v);
    logic [15:0] r;
    if (v < 50'sd0) begin
      r = 16'd0;
    end else if (v > 50'sd65535) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/slrg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slrg_div
  import slrg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVN_W-1:0] dividend_i,
  input  wire logic [DIVD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIVN_W-1:0]      quot_o,
  output logic [DIVD_W-1:0]      rem_o
);

  localparam logic [DCNT_W-1:0] LAST = DCNT_W'(DIVN_W - 1);

  logic              busy_q, done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [DIVN_W-1:0] quo_q;
  logic [DIVD_W-1:0] rem_q, dsr_q;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W+1:0] diff;
  logic              take;

  assign trial = {rem_q, quo_q[DIVN_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dsr_q};
  assign take  = ~diff[DIVD_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      quo_q <= {quo_q[DIVN_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

// ----- hdl/slrg_isqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slrg_isqrt
  import slrg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] value_i,
  output logic             done_o,
  output logic [16:0]      root_o
);

  logic        busy_q, done_q;
  logic [31:0] x_q, r_q, bit_q;
  logic [32:0] sum;
  logic        take;

  assign sum  = {1'b0, r_q} + {1'b0, bit_q};
  assign take = sum <= {1'b0, x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= value_i;
      r_q   <= '0;
      bit_q <= SQ_TOP_BIT;
    end else if (busy_q) begin
      if (take) begin
        x_q <= x_q - sum[31:0];
      end
      r_q   <= (r_q >> 1) + (take ? bit_q : 32'd0);
      bit_q <= bit_q >> 2;
    end
  end

  // round up when the leftover exceeds the root
  assign root_o = (r_q < x_q) ? (r_q[16:0] + 17'd1) : r_q[16:0];
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hdl/stepper_linear_ramp_generator.sv -----
// channel | signals                              | direction
// in      | in_valid_i, in_ready_o, in_word_i    | command or compare event word
// out     | out_valid_o, out_ready_i, out_word_o | delay and status word
// cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | register write, no wait
// a move runs the shared divider for den, min delay, ramp time, first delay, max speed and
// accel length, then decel length if needed, with the square root after the ramp time
// an event that advances accel or decel makes a divider pass, other events need none
// a move is dropped at decode, or after the first divide when the accel term rounds to zero
// one word in flight at a time; in_ready_o is high only while the sequencer idles
// a finished word waits in the output register, the next word may enter meanwhile
`timescale 1ns / 1ps
`default_nettype none

module stepper_linear_ramp_generator
  import slrg_pkg::*;
#(
  parameter int unsigned EVENTS_PER_STEP = 2
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_word_t      out_word_o,
  input  wire logic      cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned TOG_W = (EVENTS_PER_STEP > 1) ? $clog2(EVENTS_PER_STEP) : 1;
  localparam logic [TOG_W:0] TOG_WRAP = (TOG_W + 1)'(EVENTS_PER_STEP);

  seq_e state_q, state_d;

  logic [31:0] afx_q, asq_q;
  logic [15:0] fds_q, ax_q;

  logic               dir_q, running_q;
  phase_e             phase_q;
  logic [15:0]        cur_q, min_q, last_q, shown_q;
  logic [31:0]        dstart_q, steps_q;
  logic signed [32:0] dlen_q, ri_q;
  logic [33:0]        rem_q;
  logic [TOG_W-1:0]   tog_q;

  logic [31:0] mag_q, den_q, maxs_q, al_q, sq_in_q;
  logic        ndir_q;
  logic [15:0] acc_q, dec_q, spd_q;
  logic [16:0] root_q;
  logic [48:0] prod_q;
  logic        go_q;

  logic        out_valid_q;
  out_word_t   out_q;

  logic              in_acc, out_load, tog_hit, div_state, div_start, sq_start;
  logic [TOG_W:0]    tog_inc;
  logic [31:0]       raw, mul_a;
  logic [16:0]       mul_b, ad_sum;
  logic [DIVN_W-1:0] div_a, div_q;
  logic [DIVD_W-1:0] div_b, div_r;
  logic              div_done, sq_done;
  logic [16:0]       sq_root;
  logic signed [34:0] dd, dd_neg;
  logic [33:0]       dd_mag;
  logic [34:0]       num;
  logic signed [49:0] nxt_wide;
  logic [15:0]       nxt;
  logic [31:0]       len_dv, len_al, steps_inc;
  logic [15:0]       div_sat;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  assign tog_inc    = {1'b0, tog_q} + 1'b1;
  assign tog_hit    = tog_inc >= TOG_WRAP;
  assign raw        = in_word_i.move_steps;
  assign ad_sum     = {1'b0, acc_q} + {1'b0, dec_q};
  assign steps_inc  = steps_q + 32'd1;

  // recurrence divisor is 4*index+1, never zero
  assign dd     = {ri_q, 2'b01};
  assign dd_neg = -dd;
  assign dd_mag = ri_q[32] ? dd_neg[33:0] : dd[33:0];
  assign num    = {18'd0, cur_q, 1'b0} + {1'b0, rem_q};
  assign nxt_wide = ri_q[32] ? ($signed({34'd0, cur_q}) + $signed({2'b00, div_q}))
                             : ($signed({34'd0, cur_q}) - $signed({2'b00, div_q}));
  assign nxt      = sat16(nxt_wide);
  assign div_sat  = sat16($signed({2'b00, div_q}));

  assign len_al = mag_q - al_q;
  assign len_dv = (div_q == '0) ? 32'd1
                : (div_q > {16'd0, mag_q}) ? mag_q : div_q[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_DEN_MUL: begin
        mul_a = {16'd0, ax_q};
        mul_b = {1'b0, acc_q};
      end
      S_FIRST_MUL: begin
        mul_a = {16'd0, fds_q};
        mul_b = root_q;
      end
      S_MAXS_MUL: begin
        mul_a = {16'd0, spd_q};
        mul_b = {1'b0, spd_q};
      end
      S_AL_MUL: begin
        mul_a = mag_q;
        mul_b = {1'b0, dec_q};
      end
      S_DV_MUL: begin
        mul_a = maxs_q;
        mul_b = {1'b0, acc_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_a     = '0;
    div_b     = 34'd1;
    div_state = 1'b1;
    unique case (state_q)
      S_DEN_DIV, S_FIRST_DIV: begin
        div_a = prod_q[DIVN_W-1:0];
        div_b = SCALE_DIV;
      end
      S_MIN_DIV: begin
        div_a = {16'd0, afx_q};
        div_b = {18'd0, spd_q};
      end
      S_T_DIV: begin
        div_a = {16'd0, asq_q};
        div_b = {18'd0, acc_q};
      end
      S_MAXS_DIV: begin
        div_a = prod_q[DIVN_W-1:0];
        div_b = {2'd0, den_q};
      end
      S_AL_DIV: begin
        div_a = prod_q[DIVN_W-1:0];
        div_b = {17'd0, ad_sum};
      end
      S_DV_DIV: begin
        div_a = prod_q[DIVN_W-1:0];
        div_b = {18'd0, dec_q};
      end
      S_EV_DIV: begin
        div_a = {13'd0, num};
        div_b = dd_mag;
      end
      default: begin
        div_state = 1'b0;
      end
    endcase
  end

  assign div_start = div_state && !go_q;
  assign sq_start  = (state_q == S_ROOT) && !go_q;

  slrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  slrg_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_in_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.action == ACT_MOVE) begin
            state_d = S_DECODE;
          end else if (running_q) begin
            if (tog_hit && (phase_q == PH_ACCEL || phase_q == PH_DECEL)) begin
              state_d = S_EV_DIV;
            end else begin
              state_d = S_OUT;
            end
          end
        end
      end
      S_DECODE: begin
        priority if (mag_q == 32'd0) begin
          state_d = S_IDLE;
        end else if (mag_q == 32'd1) begin
          state_d = S_MV_TAIL;
        end else if (acc_q == 16'd0 || spd_q == 16'd0) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_DEN_MUL;
        end
      end
      S_DEN_MUL:   state_d = S_DEN_DIV;
      S_DEN_DIV:   if (div_done) state_d = (div_q == '0) ? S_IDLE : S_MIN_DIV;
      S_MIN_DIV:   if (div_done) state_d = S_T_DIV;
      S_T_DIV:     if (div_done) state_d = S_ROOT;
      S_ROOT:      if (sq_done) state_d = S_FIRST_MUL;
      S_FIRST_MUL: state_d = S_FIRST_DIV;
      S_FIRST_DIV: if (div_done) state_d = S_MAXS_MUL;
      S_MAXS_MUL:  state_d = S_MAXS_DIV;
      S_MAXS_DIV:  if (div_done) state_d = S_AL_MUL;
      S_AL_MUL:    state_d = S_AL_DIV;
      S_AL_DIV:    if (div_done) state_d = S_DV_CHK;
      S_DV_CHK: begin
        state_d = (al_q <= maxs_q || dec_q == 16'd0) ? S_MV_FIN : S_DV_MUL;
      end
      S_DV_MUL:    state_d = S_DV_DIV;
      S_DV_DIV:    if (div_done) state_d = S_MV_FIN;
      S_MV_FIN:    state_d = S_MV_TAIL;
      S_MV_TAIL:   state_d = S_OUT;
      S_EV_DIV:    if (div_done) state_d = S_OUT;
      S_OUT:       if (out_load) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      afx_q <= RST_ALPHA_FREQ;
      fds_q <= RST_FIRST_SCALE;
      asq_q <= RST_ALPHA_SQ;
      ax_q  <= RST_ALPHA_X20K;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ALPHA_FREQ:  afx_q <= cfg_data_i;
        CFG_FIRST_SCALE: fds_q <= cfg_data_i[15:0];
        CFG_ALPHA_SQ:    asq_q <= cfg_data_i;
        CFG_ALPHA_X20K:  ax_q  <= cfg_data_i[15:0];
        default:         afx_q <= afx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (div_start || sq_start) begin
        go_q <= 1'b1;
      end else if (div_done || sq_done) begin
        go_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.compare_delay <= shown_q;
      out_q.running       <= running_q;
      out_q.direction     <= dir_q;
      out_q.ramp_state    <= phase_q;
    end
    if (state_d != state_q || state_q != S_IDLE) begin
      prod_q <= 49'(mul_a * mul_b);
    end
    if (in_acc) begin
      mag_q  <= raw[31] ? (~raw + 32'd1) : raw;
      ndir_q <= raw[31];
      acc_q  <= in_word_i.accel_rate;
      dec_q  <= in_word_i.decel_rate;
      spd_q  <= in_word_i.top_speed;
    end
    if (div_done) begin
      unique case (state_q)
        S_DEN_DIV:  den_q   <= div_q[31:0];
        S_T_DIV:    sq_in_q <= div_q[31:0];
        S_MAXS_DIV: maxs_q  <= (div_q == '0) ? 32'd1 : div_q[31:0];
        S_AL_DIV:   al_q    <= (div_q == '0) ? 32'd1 : div_q[31:0];
        default:    den_q   <= den_q;
      endcase
    end
    if (sq_done) begin
      root_q <= sq_root;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      phase_q   <= PH_STOP;
      cur_q     <= '0;
      min_q     <= '0;
      dstart_q  <= '0;
      dlen_q    <= '0;
      ri_q      <= '0;
      steps_q   <= '0;
      rem_q     <= '0;
      last_q    <= '0;
      tog_q     <= '0;
      running_q <= 1'b0;
      shown_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && in_word_i.action == ACT_EVENT && running_q) begin
            shown_q <= cur_q;
            if (!tog_hit) begin
              tog_q <= tog_inc[TOG_W-1:0];
            end else begin
              tog_q <= '0;
              unique case (phase_q)
                PH_STOP: begin
                  steps_q   <= '0;
                  rem_q     <= '0;
                  running_q <= 1'b0;
                end
                PH_RUN: begin
                  steps_q <= steps_inc;
                  if (steps_inc >= dstart_q) begin
                    ri_q    <= dlen_q;
                    cur_q   <= last_q;
                    phase_q <= PH_DECEL;
                  end else begin
                    cur_q <= min_q;
                  end
                end
                default: begin
                  steps_q <= steps_inc;
                  ri_q    <= ri_q + 33'sd1;
                end
              endcase
            end
          end
        end
        S_DECODE: begin
          if (mag_q == 32'd0) begin
            dir_q <= ndir_q;
          end else if (mag_q == 32'd1) begin
            dir_q   <= ndir_q;
            ri_q    <= '1;
            phase_q <= PH_DECEL;
            cur_q   <= SINGLE_DELAY;
          end
        end
        S_DEN_DIV: begin
          if (div_done && div_q != '0) begin
            dir_q <= ndir_q;
          end
        end
        S_MIN_DIV: begin
          if (div_done) begin
            min_q <= div_sat;
          end
        end
        S_FIRST_DIV: begin
          if (div_done) begin
            cur_q <= div_sat;
          end
        end
        S_DV_CHK: begin
          if (al_q <= maxs_q || dec_q == 16'd0) begin
            dlen_q   <= -$signed({1'b0, len_al});
            dstart_q <= mag_q - len_al;
          end
        end
        S_DV_DIV: begin
          if (div_done) begin
            dlen_q   <= -$signed({1'b0, len_dv});
            dstart_q <= mag_q - len_dv;
          end
        end
        S_MV_FIN: begin
          ri_q <= '0;
          if (cur_q <= min_q) begin
            cur_q   <= min_q;
            phase_q <= PH_RUN;
          end else begin
            phase_q <= PH_ACCEL;
          end
        end
        S_MV_TAIL: begin
          steps_q   <= '0;
          rem_q     <= '0;
          tog_q     <= '0;
          running_q <= 1'b1;
          shown_q   <= MOVE_DELAY;
        end
        S_EV_DIV: begin
          if (div_done) begin
            rem_q <= div_r;
            cur_q <= nxt;
            if (phase_q == PH_ACCEL) begin
              if (steps_q >= dstart_q) begin
                ri_q    <= dlen_q;
                phase_q <= PH_DECEL;
              end else if (nxt <= min_q) begin
                last_q  <= nxt;
                cur_q   <= min_q;
                rem_q   <= '0;
                phase_q <= PH_RUN;
              end
            end else if (!ri_q[32]) begin
              phase_q <= PH_STOP;
            end
          end
        end
        default: begin
          shown_q <= shown_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ----- tb/stepper_linear_ramp_generator_tb.sv -----
`timescale 1ns / 1ps

module stepper_linear_ramp_generator_tb;
  import slrg_pkg::*;

  localparam int unsigned STEP_EVENTS = 2;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 500;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_word_t    in_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_word_t   out_word;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_ALPHA_FREQ;
  logic [31:0] cfg_data = '0;

  stepper_linear_ramp_generator #(.EVENTS_PER_STEP(STEP_EVENTS)) u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_word_o(out_word),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor copy of configuration and ramp state
  logic [31:0] p_alpha_freq = RST_ALPHA_FREQ;
  logic [15:0] p_first_scale = RST_FIRST_SCALE;
  logic [31:0] p_alpha_sq = RST_ALPHA_SQ;
  logic [15:0] p_alpha_x20k = RST_ALPHA_X20K;

  logic        p_dir = 1'b0;
  phase_e      p_phase = PH_STOP;
  logic [15:0] p_delay = '0;
  logic [15:0] p_min_delay = '0;
  logic [31:0] p_decel_start = '0;
  longint      p_decel_len = 0;
  longint      p_index = 0;
  logic [31:0] p_steps_done = '0;
  longint      p_rem = 0;
  logic [15:0] p_last_accel = '0;
  int unsigned p_toggle = 0;
  logic        p_running = 1'b0;

  out_word_t   expected_status_q[$];
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned cycles = 0;

  function automatic logic [15:0] clamp_delay(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic longint unsigned rounded_root(input logic [31:0] v);
    longint unsigned x, r, b;
    logic take;
    x = v;
    r = 0;
    b = 64'h4000_0000;
    while (b != 0) begin
      take = (r + b) <= x;
      if (take) x = x - (r + b);
      r = r >> 1;
      if (take) r = r + b;
      b = b >> 2;
    end
    return (r < x) ? r + 1 : r;
  endfunction

  function automatic logic [15:0] next_ramp_delay();
    longint num, dd, q;
    p_index = p_index + 1;
    dd = 4 * p_index + 1;
    num = 2 * longint'(p_delay) + p_rem;
    q = num / dd;
    p_rem = num % dd;
    return clamp_delay(longint'(p_delay) - q);
  endfunction

  function automatic void push_status(input logic [15:0] d);
    out_word_t w;
    w.compare_delay = d;
    w.running = p_running;
    w.direction = p_dir;
    w.ramp_state = p_phase;
    expected_status_q.push_back(w);
  endfunction

  function automatic void predict_move(input in_word_t w);
    logic [31:0] raw;
    logic ndir;
    longint unsigned mag, acc, dec, spd, den, maxs, al, first;
    longint dv;
    raw = w.move_steps;
    ndir = raw[31];
    mag = ndir ? longint'(32'(-raw)) : longint'(raw);
    if (ndir && mag == 0) mag = 64'h8000_0000;
    acc = w.accel_rate;
    dec = w.decel_rate;
    spd = w.top_speed;
    if (mag == 0) begin
      p_dir = ndir;
      return;
    end
    if (mag == 1) begin
      p_dir = ndir;
      p_index = -1;
      p_phase = PH_DECEL;
      p_delay = SINGLE_DELAY;
    end else begin
      if (spd == 0 || acc == 0) return;
      den = (longint'(p_alpha_x20k) * acc) / 100;
      if (den == 0) return;
      p_dir = ndir;
      p_min_delay = clamp_delay(longint'(longint'(p_alpha_freq) / spd));
      first = (longint'(p_first_scale) * rounded_root(32'(longint'(p_alpha_sq) / acc))) / 100;
      p_delay = clamp_delay(first);
      maxs = (spd * spd) / den;
      if (maxs == 0) maxs = 1;
      al = (mag * dec) / (acc + dec);
      if (al == 0) al = 1;
      if (al <= maxs || dec == 0) dv = longint'(al) - longint'(mag);
      else dv = -longint'((maxs * acc) / dec);
      if (dv == 0) dv = -1;
      if (dv < -longint'(mag)) dv = -longint'(mag);
      p_decel_len = dv;
      p_decel_start = 32'(longint'(mag) + dv);
      if (p_delay <= p_min_delay) begin
        p_delay = p_min_delay;
        p_phase = PH_RUN;
      end else begin
        p_phase = PH_ACCEL;
      end
      p_index = 0;
    end
    p_steps_done = '0;
    p_rem = 0;
    p_toggle = 0;
    p_running = 1'b1;
    push_status(MOVE_DELAY);
  endfunction

  function automatic void predict_event();
    logic [15:0] shown, nxt;
    shown = p_delay;
    nxt = p_delay;
    if (!p_running) return;
    p_toggle = p_toggle + 1;
    if (p_toggle >= STEP_EVENTS) begin
      p_toggle = 0;
      case (p_phase)
        PH_STOP: begin
          p_steps_done = '0;
          p_rem = 0;
          p_running = 1'b0;
        end
        PH_ACCEL: begin
          p_steps_done = p_steps_done + 1;
          nxt = next_ramp_delay();
          if (p_steps_done >= p_decel_start) begin
            p_index = p_decel_len;
            p_phase = PH_DECEL;
          end else if (nxt <= p_min_delay) begin
            p_last_accel = nxt;
            nxt = p_min_delay;
            p_rem = 0;
            p_phase = PH_RUN;
          end
        end
        PH_RUN: begin
          p_steps_done = p_steps_done + 1;
          nxt = p_min_delay;
          if (p_steps_done >= p_decel_start) begin
            p_index = p_decel_len;
            nxt = p_last_accel;
            p_phase = PH_DECEL;
          end
        end
        default: begin
          p_steps_done = p_steps_done + 1;
          nxt = next_ramp_delay();
          if (p_index >= 0) p_phase = PH_STOP;
        end
      endcase
      p_delay = nxt;
    end
    push_status(shown);
  endfunction

  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (w.action == ACT_MOVE) predict_move(w);
    else predict_event();
  endtask

  task automatic send_move(input logic [31:0] steps, input logic [15:0] acc,
                           input logic [15:0] dec, input logic [15:0] spd);
    in_word_t w;
    w.action = ACT_MOVE;
    w.move_steps = steps;
    w.accel_rate = acc;
    w.decel_rate = dec;
    w.top_speed = spd;
    send_word(w);
  endtask

  task automatic send_event();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom, $urandom});
    w.action = ACT_EVENT;
    send_word(w);
  endtask

  task automatic run_events(input int unsigned cap);
    int unsigned n;
    n = 0;
    while (p_running && n < cap) begin
      send_event();
      n++;
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ALPHA_FREQ: p_alpha_freq = data;
      CFG_FIRST_SCALE: p_first_scale = data[15:0];
      CFG_ALPHA_SQ: p_alpha_sq = data;
      default: p_alpha_x20k = data[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [31:0] f, input logic [15:0] s,
                           input logic [31:0] q, input logic [15:0] x);
    settle();
    write_reg(CFG_ALPHA_FREQ, f);
    write_reg(CFG_FIRST_SCALE, {16'd0, s});
    write_reg(CFG_ALPHA_SQ, q);
    write_reg(CFG_ALPHA_X20K, {16'd0, x});
  endtask

  task automatic ramp_sequence();
    send_move($urandom_range(0, 1) ? -$urandom_range(2, 40) : $urandom_range(2, 40),
              $urandom_range(50, 3000), $urandom_range(0, 3000), $urandom_range(100, 4000));
    run_events(300);
  endtask

  task automatic test_directed();
    send_event();
    send_move(32'd0, 16'd100, 16'd100, 16'd100);
    send_move(32'd1, 16'd0, 16'd0, 16'd0);
    run_events(10);
    send_move(-32'sd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_events(10);
    send_move(32'd10, 16'd0, 16'd500, 16'd500);
    send_move(32'd10, 16'd500, 16'd500, 16'd0);
    send_move(32'h8000_0000, 16'd1000, 16'd1000, 16'd1000);
    send_event();
    send_event();
    send_event();
    send_move(32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_event();
    send_event();
    send_move(32'd3, 16'd1, 16'd0, 16'd1);
    run_events(12);
  endtask

  task automatic test_config_extremes();
    write_all(32'd1, 16'd1, 32'd1, 16'd1);
    send_move(32'd8, 16'd50, 16'd50, 16'd50);
    send_move(32'd8, 16'd200, 16'd100, 16'd1);
    run_events(40);
    write_all(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_move(32'd12, 16'd1, 16'd3, 16'hFFFF);
    run_events(60);
    ramp_sequence();
    write_all($urandom, 16'($urandom_range(1, 65535)), $urandom, 16'($urandom_range(1, 65535)));
    ramp_sequence();
    write_all(RST_ALPHA_FREQ, RST_FIRST_SCALE, RST_ALPHA_SQ, RST_ALPHA_X20K);
  endtask

  task automatic test_random(input int unsigned target);
    in_word_t w;
    while (items_sent < target) begin
      case ($urandom_range(9))
        0: begin
          w = in_word_t'({$urandom, $urandom, $urandom});
          send_word(w);
        end
        1: begin
          send_move($urandom_range(2, 30), $urandom_range(50, 3000),
                    $urandom_range(0, 3000), $urandom_range(100, 4000));
          run_events($urandom_range(1, 15));
        end
        default: ramp_sequence();
      endcase
    end
  endtask

  task automatic test_pressure();
    ramp_sequence();
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    ramp_sequence();
  endtask

  always @(posedge clk) begin
    out_word_t e;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      if (expected_status_q.size() == 0) begin
        $error("unexpected word %h", out_word);
        errors++;
      end else begin
        e = expected_status_q.pop_front();
        if (out_word.compare_delay !== e.compare_delay) begin
          $error("compare_delay exp %0d got %0d", e.compare_delay, out_word.compare_delay);
          errors++;
        end
        if (out_word.running !== e.running) begin
          $error("running exp %0d got %0d", e.running, out_word.running);
          errors++;
        end
        if (out_word.direction !== e.direction) begin
          $error("direction exp %0d got %0d", e.direction, out_word.direction);
          errors++;
        end
        if (out_word.ramp_state !== e.ramp_state) begin
          $error("ramp_state exp %0d got %0d", e.ramp_state, out_word.ramp_state);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 68;
    test_directed();
    test_config_extremes();
    test_random(260);
    test_pressure();
    send_idle_pct = 68;
    recv_idle_pct = 14;
    test_random(480);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(640);
    settle();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
